FILE: src/assert_macros.svh
// Assertion macros used by the checker module of the project.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/u8u16_pkg.sv
// Types and constants of the UTF-8 to UTF-16 decoder.
// Used by the decode logic, the top level and the checker.
package u8u16_pkg;

  localparam int UnitW    = 21;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [UnitW-1:0] Replacement = 21'h00fffd;
  localparam logic [UnitW-1:0] SurHiBase   = 21'h00d800;
  localparam logic [UnitW-1:0] SurLoBase   = 21'h00dc00;
  localparam logic [UnitW-1:0] PlaneOne    = 21'h010000;
  localparam logic [UnitW-1:0] BmpMax      = 21'h00ffff;

  localparam logic [0:0] RegSixteenBit = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [1:0] bytes_after;
  } in_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]       res_cnt;
    out_t             res0;
    out_t             res1;
    logic [1:0]       pending_nxt;
    logic [UnitW-1:0] partial_nxt;
  } dec_t;

endpackage

FILE: src/utf8_to_utf16_decoder_unit.sv
// Top level of the lenient UTF-8 to UTF-16 decoder: config port, decode step
// and a two-entry result queue. Depends on u8u16_pkg and u8u16_decode.
//
// One byte is taken per cycle and decoded in the same cycle into a two-entry
// result queue; its first result is shown the following cycle. The queue sets
// the rate: with the result side not stalling, a byte is taken every cycle,
// except that after a byte producing a surrogate pair no byte is taken while
// the low half drains. Bytes that only extend a sequence produce no result.
// Register 0 at byte address 0, bit 0: sixteen_bit_units (reset 1).
module utf8_to_utf16_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  u8u16_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output u8u16_pkg::out_t                   out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [u8u16_pkg::CfgAddrW-1:0]    paddr,
  input  logic [u8u16_pkg::CfgDataW-1:0]    pwdata,
  output logic [u8u16_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready
);

  logic                        sixteen_r, sixteen_nxt;
  logic [1:0]                  pending_r, pending_nxt;
  logic [u8u16_pkg::UnitW-1:0] partial_r, partial_nxt;
  logic                        q0_v_r, q0_v_nxt, q1_v_r, q1_v_nxt;
  u8u16_pkg::out_t             q0_r, q0_nxt, q1_r, q1_nxt;
  u8u16_pkg::dec_t             dec;
  logic                        accept, drain, cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite
                     && (paddr[u8u16_pkg::CfgAddrW-1] == u8u16_pkg::RegSixteenBit);
  assign prdata    = (paddr[u8u16_pkg::CfgAddrW-1] == u8u16_pkg::RegSixteenBit)
                     ? {{(u8u16_pkg::CfgDataW-1){1'b0}}, sixteen_r} : '0;
  assign sixteen_nxt = cfg_wr ? pwdata[0] : sixteen_r;

  assign out_valid = q0_v_r;
  assign out_data  = q0_r;
  assign drain     = q0_v_r && !out_stall;
  assign in_stall  = q1_v_r || (q0_v_r && out_stall);
  assign accept    = in_valid && !in_stall;

  u8u16_decode u_decode (
    .item        (in_data),
    .pending     (pending_r),
    .partial     (partial_r),
    .sixteen_bit (sixteen_r),
    .dec         (dec)
  );

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    q0_v_nxt    = drain ? q1_v_r : q0_v_r;
    q0_nxt      = drain ? q1_r : q0_r;
    q1_v_nxt    = drain ? 1'b0 : q1_v_r;
    q1_nxt      = q1_r;
    if (accept) begin
      pending_nxt = dec.pending_nxt;
      partial_nxt = dec.partial_nxt;
      q0_v_nxt    = (dec.res_cnt != 2'd0);
      q0_nxt      = dec.res0;
      q1_v_nxt    = (dec.res_cnt == 2'd2);
      q1_nxt      = dec.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sixteen_r <= 1'b1;
      pending_r <= 2'd0;
      partial_r <= '0;
      q0_v_r    <= 1'b0;
      q1_v_r    <= 1'b0;
    end else begin
      sixteen_r <= sixteen_nxt;
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
      q0_v_r    <= q0_v_nxt;
      q1_v_r    <= q1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

FILE: src/u8u16_decode.sv
// Per-byte decode step: next sequence state and up to two result units.
// Depends on u8u16_pkg.
module u8u16_decode (
  input  u8u16_pkg::in_t                 item,
  input  logic [1:0]                     pending,
  input  logic [u8u16_pkg::UnitW-1:0]    partial,
  input  logic                           sixteen_bit,
  output u8u16_pkg::dec_t                dec
);

  logic [u8u16_pkg::UnitW-1:0] cont_bits;
  logic [u8u16_pkg::UnitW-1:0] merged;
  logic [u8u16_pkg::UnitW-1:0] cp;
  logic [u8u16_pkg::UnitW-1:0] diff;
  logic                        emit;
  logic [7:0]                  b;

  assign b    = item.in_byte;
  assign diff = cp - u8u16_pkg::PlaneOne;

  always_comb begin
    cont_bits = {{(u8u16_pkg::UnitW-6){1'b0}}, b[5:0]};
    unique case (pending)
      2'd2:    merged = partial | (cont_bits << 6);
      2'd3:    merged = partial | (cont_bits << 12);
      default: merged = partial | cont_bits;
    endcase
  end

  always_comb begin
    dec.pending_nxt = pending;
    dec.partial_nxt = partial;
    emit            = 1'b0;
    cp              = u8u16_pkg::Replacement;
    if (pending != 2'd0) begin
      dec.pending_nxt = pending - 2'd1;
      if (pending == 2'd1) begin
        emit            = 1'b1;
        cp              = merged;
        dec.partial_nxt = '0;
      end else begin
        dec.partial_nxt = merged;
      end
    end else if (!b[7]) begin
      emit = 1'b1;
      cp   = {{(u8u16_pkg::UnitW-8){1'b0}}, b};
    end else if (b[7:5] == 3'b110 && item.bytes_after >= 2'd1) begin
      dec.pending_nxt = 2'd1;
      dec.partial_nxt = {{(u8u16_pkg::UnitW-11){1'b0}}, b[4:0], 6'd0};
    end else if (b[7:4] == 4'b1110 && item.bytes_after >= 2'd2) begin
      dec.pending_nxt = 2'd2;
      dec.partial_nxt = {{(u8u16_pkg::UnitW-16){1'b0}}, b[3:0], 12'd0};
    end else if (b[7:3] == 5'b11110 && item.bytes_after == 2'd3) begin
      dec.pending_nxt = 2'd3;
      dec.partial_nxt = {b[2:0], 18'd0};
    end else begin
      emit = 1'b1;
    end
  end

  always_comb begin
    dec.res_cnt          = 2'd0;
    dec.res0.code_unit   = cp;
    dec.res0.last_of_run = 1'b1;
    dec.res1.code_unit   = u8u16_pkg::SurLoBase
                         + {{(u8u16_pkg::UnitW-10){1'b0}}, diff[9:0]};
    dec.res1.last_of_run = 1'b1;
    if (emit) begin
      dec.res_cnt = 2'd1;
      if (sixteen_bit && cp > u8u16_pkg::BmpMax) begin
        dec.res_cnt          = 2'd2;
        dec.res0.code_unit   = u8u16_pkg::SurHiBase
                             + {{10{1'b0}}, diff[u8u16_pkg::UnitW-1:10]};
        dec.res0.last_of_run = 1'b0;
      end
    end
  end

endmodule

FILE: src/u8u16_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input u8u16_pkg::out_t out_data
);

  logic out_wait;
  logic out_take;
  logic hi_take;
  logic hi_shown;
  logic low_shown;
  logic hi_in_range;

  assign out_wait    = out_valid && out_stall;
  assign out_take    = out_valid && !out_stall;
  assign hi_take     = out_take && !out_data.last_of_run;
  assign hi_shown    = out_valid && !out_data.last_of_run;
  assign low_shown   = out_valid && out_data.last_of_run;
  assign hi_in_range = (out_data.code_unit >= u8u16_pkg::SurHiBase)
                       && (out_data.code_unit < u8u16_pkg::Replacement);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data))
  `ASSERT_NEXT(a_low_follows, clk, rst_n, hi_take, low_shown)
  `ASSERT_NOW(a_high_range, clk, rst_n, hi_shown, hi_in_range)

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
